@@ design/cnm_pkg.sv @@
package cnm_pkg;

    // Port widths fixed by the interface
    localparam int SLOT_W     = 6;
    localparam int INDEX_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int VLEN_W     = 10;
    localparam int UCNT_W     = 7;
    localparam int THR_W      = 16;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_USERS  = 64;
    localparam int DEF_MAX_DIM    = 512;
    localparam int DEF_ELEM_WIDTH = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [VLEN_W-1:0] VLEN_RESET = 10'd128;
    localparam logic [UCNT_W-1:0] UCNT_RESET = 7'd0;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd19661;

    // Item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // What the front end decided an item has to do
    typedef struct packed {
        logic wr_ref;
        logic wr_qry;
        logic search;
    } t_cmd_flags;

    // Back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_back_stat;

endpackage

@@ design/cosine_nearest_match.sv @@
// Channel   valid         ready         payload
// in        i_in_valid    o_in_ready    i_kind i_user_slot i_element_index
//                                       i_element_value i_last
// out       o_out_valid   i_out_ready   o_best_user o_best_similarity o_matched
// cfg       i_cfg_valid   o_cfg_ready   i_cfg_index i_cfg_data
//
// The back end takes store and query requests while idle; a two-entry queue
// in front takes requests while a search runs, then drops o_in_ready.
// A search sums the query norm and takes its integer root, then per user
// sums the dot product and reference norm, takes a root and does D = 57
// divider steps; a slot with a zero norm skips root and divide. The single
// reference memory read port and the serial divider set the search time.
// Reset (i_rst_n low, synchronous) empties the queue and the result
// register; the vector stores are not cleared and read garbage until written.
// A stalled result holds the back end in its final state; the queue then
// fills and the front drops o_in_ready.
module cosine_nearest_match
    import cnm_pkg::*;
#(
    parameter int MAX_USERS  = DEF_MAX_USERS,
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [SLOT_W-1:0]     i_user_slot,
    input  logic [INDEX_W-1:0]    i_element_index,
    input  logic [ELEM_WIDTH-1:0] i_element_value,
    input  logic                  i_last,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SLOT_W-1:0]     o_best_user,
    output logic [ELEM_WIDTH-1:0] o_best_similarity,
    output logic                  o_matched,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int UIW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // configuration registers
    logic [VLEN_W-1:0] r_vlen, n_vlen;
    logic [UCNT_W-1:0] r_ucnt, n_ucnt;
    logic [THR_W-1:0]  r_thr, n_thr;

    // queue to back end
    logic                  w_cmd_valid;
    t_cmd_flags            w_cmd_flags;
    logic [UIW-1:0]        w_cmd_slot;
    logic [IW-1:0]         w_cmd_idx;
    logic [ELEM_WIDTH-1:0] w_cmd_value;
    logic                  w_cmd_pop;
    t_back_stat            w_stat;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_vlen = r_vlen;
        n_ucnt = r_ucnt;
        n_thr  = r_thr;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_VECTOR_LENGTH: n_vlen = i_cfg_data[VLEN_W-1:0];
                CFG_USER_COUNT:    n_ucnt = i_cfg_data[UCNT_W-1:0];
                CFG_THRESHOLD:     n_thr  = i_cfg_data[THR_W-1:0];
                default: begin
                    // unknown index: dropped
                    n_vlen = r_vlen;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RESET;
            r_ucnt <= UCNT_RESET;
            r_thr  <= THR_RESET;
        end else begin
            r_vlen <= n_vlen;
            r_ucnt <= n_ucnt;
            r_thr  <= n_thr;
        end
    end

    // front: accept, range-check and queue requests
    cnm_front #(
        .MAX_USERS  (MAX_USERS),
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_user_slot     (i_user_slot),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_last          (i_last),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd_flags     (w_cmd_flags),
        .o_cmd_slot      (w_cmd_slot),
        .o_cmd_idx       (w_cmd_idx),
        .o_cmd_value     (w_cmd_value),
        .i_cmd_pop       (w_cmd_pop)
    );

    // back: vector stores, norms, dot products, root, divide, best-of
    cnm_back #(
        .MAX_USERS  (MAX_USERS),
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vlen            (r_vlen),
        .i_ucnt            (r_ucnt),
        .i_thr             (r_thr),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd_flags       (w_cmd_flags),
        .i_cmd_slot        (w_cmd_slot),
        .i_cmd_idx         (w_cmd_idx),
        .i_cmd_value       (w_cmd_value),
        .o_cmd_pop         (w_cmd_pop),
        .o_stat            (w_stat),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_best_user       (o_best_user),
        .o_best_similarity (o_best_similarity),
        .o_matched         (o_matched)
    );

    // sign-extended views for the threshold check
    logic signed [32:0] w_sim33;
    logic signed [32:0] w_thr33;
    assign w_sim33 = {{(33-ELEM_WIDTH){o_best_similarity[ELEM_WIDTH-1]}}, o_best_similarity};
    assign w_thr33 = {{(33-THR_W){r_thr[THR_W-1]}}, r_thr};

`ifndef NO_ASSERTIONS
    // a fresh result only follows a finished search
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_stat.done))
        else $error("result without finished search");

    // a match flag never contradicts the threshold
    a_match_meets_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_matched) |-> (w_sim33 >= w_thr33))
        else $error("match below threshold");

    // the back end only pops the queue while idle
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_stat.idle && w_cmd_valid))
        else $error("queue popped while busy");
`endif

endmodule

@@ design/cnm_front.sv @@
module cnm_front
    import cnm_pkg::*;
#(
    parameter int MAX_USERS  = DEF_MAX_USERS,
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [SLOT_W-1:0]     i_user_slot,
    input  logic [INDEX_W-1:0]    i_element_index,
    input  logic [ELEM_WIDTH-1:0] i_element_value,
    input  logic                  i_last,
    output logic                  o_cmd_valid,
    output t_cmd_flags            o_cmd_flags,
    output logic [((MAX_USERS > 1) ? $clog2(MAX_USERS) : 1)-1:0] o_cmd_slot,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]     o_cmd_idx,
    output logic [ELEM_WIDTH-1:0] o_cmd_value,
    input  logic                  i_cmd_pop
);

    localparam int UIW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // two-entry request queue
    t_cmd_flags            r_flags [2];
    logic [UIW-1:0]        r_slot  [2];
    logic [IW-1:0]         r_idx   [2];
    logic [ELEM_WIDTH-1:0] r_value [2];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_count, n_count;

    logic       w_push;
    logic [31:0] w_slot32;
    logic [31:0] w_idx32;
    t_cmd_flags w_flags;

    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_slot32   = 32'(i_user_slot);
    assign w_idx32    = 32'(i_element_index);

    // classify: out-of-range writes are dropped, last only counts on a query
    always_comb begin
        w_flags.wr_ref = (i_kind == KIND_STORE) && (w_slot32 < MAX_USERS)
                         && (w_idx32 < MAX_DIM);
        w_flags.wr_qry = (i_kind == KIND_QUERY) && (w_idx32 < MAX_DIM);
        w_flags.search = (i_kind == KIND_QUERY) && i_last;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_flags[r_wr_ptr] <= w_flags;
            r_slot[r_wr_ptr]  <= w_slot32[UIW-1:0];
            r_idx[r_wr_ptr]   <= w_idx32[IW-1:0];
            r_value[r_wr_ptr] <= i_element_value;
        end
    end

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd_flags = r_flags[r_rd_ptr];
    assign o_cmd_slot  = r_slot[r_rd_ptr];
    assign o_cmd_idx   = r_idx[r_rd_ptr];
    assign o_cmd_value = r_value[r_rd_ptr];

endmodule

@@ design/cnm_back.sv @@
module cnm_back
    import cnm_pkg::*;
#(
    parameter int MAX_USERS  = DEF_MAX_USERS,
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VLEN_W-1:0]     i_vlen,
    input  logic [UCNT_W-1:0]     i_ucnt,
    input  logic [THR_W-1:0]      i_thr,
    input  logic                  i_cmd_valid,
    input  t_cmd_flags            i_cmd_flags,
    input  logic [((MAX_USERS > 1) ? $clog2(MAX_USERS) : 1)-1:0] i_cmd_slot,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]     i_cmd_idx,
    input  logic [ELEM_WIDTH-1:0] i_cmd_value,
    output logic                  o_cmd_pop,
    output t_back_stat            o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SLOT_W-1:0]     o_best_user,
    output logic [ELEM_WIDTH-1:0] o_best_similarity,
    output logic                  o_matched
);

    localparam int EW  = ELEM_WIDTH;
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int UIW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int UCW = $clog2(MAX_USERS + 1);
    localparam int RD  = MAX_USERS * MAX_DIM;
    localparam int AW  = (RD > 1) ? $clog2(RD) : 1;
    localparam int NW  = 2 * EW + CW;
    localparam int SW  = (NW + 1) / 2;
    localparam int XW  = 2 * SW;
    localparam int DNW = 2 * SW;
    localparam int MW  = NW + EW - 1;
    localparam int KW  = $clog2(MW + 1);

    localparam logic [EW-1:0] SIM_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] SIM_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [XW-1:0] SQ_TOP  = XW'(1) << (XW - 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NA   = 4'd1;
    localparam logic [3:0] S_SQA  = 4'd2;
    localparam logic [3:0] S_DOT  = 4'd3;
    localparam logic [3:0] S_SQB  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_RND  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [EW-1:0] m_ref [RD];
    logic [EW-1:0] m_qry [MAX_DIM];

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_len, n_len;
    logic [UCW-1:0]       r_users, n_users;
    logic [CW-1:0]        r_i, n_i;
    logic [UCW-1:0]       r_u, n_u;
    logic                 r_rd_vld, n_rd_vld;
    logic [AW-1:0]        r_base, n_base;
    logic [NW-1:0]        r_na, n_na;
    logic signed [NW-1:0] r_dot, n_dot;
    logic [NW-1:0]        r_nb, n_nb;
    logic [SW-1:0]        r_sa, n_sa;
    logic [XW-1:0]        r_sq_x, n_sq_x;
    logic [XW-1:0]        r_sq_r, n_sq_r;
    logic [XW-1:0]        r_sq_bit, n_sq_bit;
    logic [DNW-1:0]       r_den, n_den;
    logic [MW-1:0]        r_m, n_m;
    logic [DNW-1:0]       r_rem, n_rem;
    logic [MW-1:0]        r_q, n_q;
    logic [KW-1:0]        r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic [EW-1:0]        r_sim, n_sim;
    logic [EW-1:0]        r_best, n_best;
    logic [UIW-1:0]       r_bu, n_bu;
    logic                 r_found, n_found;
    logic                 r_ov, n_ov;
    logic [SLOT_W-1:0]    r_obu, n_obu;
    logic [EW-1:0]        r_osim, n_osim;
    logic                 r_omatch, n_omatch;
    logic [EW-1:0]        r_qdat;
    logic [EW-1:0]        r_rdat;

    // memory control
    logic          w_rd_en;
    logic [AW-1:0] w_ref_waddr;
    logic [AW-1:0] w_ref_raddr;
    logic          w_ref_we;
    logic          w_qry_we;

    // datapath helpers
    logic [31:0]           w_len32, w_users32, w_bu32;
    logic signed [2*EW-1:0] w_qq, w_qr, w_rr;
    logic [XW-1:0]         w_sq_sum;
    logic [NW-1:0]         w_mag;
    logic [DNW:0]          w_rem2;
    logic [MW:0]           w_qr_rnd;
    logic                  w_round_up;
    logic                  w_load_out;
    logic                  w_degenerate;

    assign w_len32   = (32'(i_vlen) > MAX_DIM) ? MAX_DIM : 32'(i_vlen);
    assign w_users32 = (32'(i_ucnt) > MAX_USERS) ? MAX_USERS : 32'(i_ucnt);

    assign o_cmd_pop = i_cmd_valid && (r_state == S_IDLE);
    assign w_ref_we  = o_cmd_pop && i_cmd_flags.wr_ref;
    assign w_qry_we  = o_cmd_pop && i_cmd_flags.wr_qry;
    assign w_ref_waddr = AW'(32'(i_cmd_slot) * MAX_DIM + 32'(i_cmd_idx));
    assign w_ref_raddr = r_base + AW'(r_i);
    assign w_rd_en   = ((r_state == S_NA) || (r_state == S_DOT)) && (r_i < r_len);

    always_ff @(posedge i_clk) begin
        if (w_ref_we) begin
            m_ref[w_ref_waddr] <= i_cmd_value;
        end
        if (w_rd_en) begin
            r_rdat <= m_ref[w_ref_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qry_we) begin
            m_qry[i_cmd_idx] <= i_cmd_value;
        end
        if (w_rd_en) begin
            r_qdat <= m_qry[r_i[IW-1:0]];
        end
    end

    assign w_qq = $signed(r_qdat) * $signed(r_qdat);
    assign w_qr = $signed(r_qdat) * $signed(r_rdat);
    assign w_rr = $signed(r_rdat) * $signed(r_rdat);

    assign w_sq_sum = r_sq_r + r_sq_bit;
    assign w_mag    = r_dot[NW-1] ? NW'(-r_dot) : NW'(r_dot);
    assign w_rem2   = {r_rem, r_m[MW-1]};
    assign w_round_up = ({1'b0, r_rem} << 1) >= {1'b0, r_den};
    assign w_qr_rnd = {1'b0, r_q} + (MW+1)'(w_round_up);
    assign w_degenerate = (r_na == '0) || (r_nb == '0)
                          || ((r_na == NW'(1)) && (r_nb == NW'(1)));
    assign w_load_out = !r_ov || i_out_ready;
    assign w_bu32 = 32'(r_bu);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_users  = r_users;
        n_i      = r_i;
        n_u      = r_u;
        n_rd_vld = 1'b0;
        n_base   = r_base;
        n_na     = r_na;
        n_dot    = r_dot;
        n_nb     = r_nb;
        n_sa     = r_sa;
        n_sq_x   = r_sq_x;
        n_sq_r   = r_sq_r;
        n_sq_bit = r_sq_bit;
        n_den    = r_den;
        n_m      = r_m;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_sim    = r_sim;
        n_best   = r_best;
        n_bu     = r_bu;
        n_found  = r_found;
        n_ov     = r_ov;
        n_obu    = r_obu;
        n_osim   = r_osim;
        n_omatch = r_omatch;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        if (w_rd_en) begin
            n_i      = CW'(r_i + 1'b1);
            n_rd_vld = 1'b1;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (o_cmd_pop && i_cmd_flags.search) begin
                    n_len   = w_len32[CW-1:0];
                    n_users = w_users32[UCW-1:0];
                    n_i     = '0;
                    n_na    = '0;
                    n_state = S_NA;
                end
            end
            S_NA: begin
                if (r_rd_vld) begin
                    n_na = r_na + NW'(w_qq);
                end
                if (!w_rd_en && !r_rd_vld) begin
                    n_best  = SIM_MIN;
                    n_bu    = '0;
                    n_found = 1'b0;
                    if (r_users == '0) begin
                        n_best  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_sq_x   = XW'(r_na);
                        n_sq_r   = '0;
                        n_sq_bit = SQ_TOP;
                        n_state  = S_SQA;
                    end
                end
            end
            S_SQA, S_SQB: begin
                if (r_sq_bit == '0) begin
                    if (r_state == S_SQA) begin
                        n_sa    = r_sq_r[SW-1:0];
                        n_u     = '0;
                        n_base  = '0;
                        n_i     = '0;
                        n_dot   = '0;
                        n_nb    = '0;
                        n_state = S_DOT;
                    end else begin
                        n_den   = DNW'(r_sa) * DNW'(r_sq_r[SW-1:0]);
                        n_neg   = r_dot[NW-1];
                        n_m     = {w_mag, {(EW-1){1'b0}}};
                        n_rem   = '0;
                        n_q     = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end else begin
                    if (r_sq_x >= w_sq_sum) begin
                        n_sq_x = r_sq_x - w_sq_sum;
                        n_sq_r = (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        n_sq_r = r_sq_r >> 1;
                    end
                    n_sq_bit = r_sq_bit >> 2;
                end
            end
            S_DOT: begin
                if (r_rd_vld) begin
                    n_dot = r_dot + NW'(w_qr);
                    n_nb  = r_nb + NW'(w_rr);
                end
                if (!w_rd_en && !r_rd_vld) begin
                    if (w_degenerate) begin
                        n_sim   = '0;
                        n_state = S_CMP;
                    end else begin
                        n_sq_x   = XW'(r_nb);
                        n_sq_r   = '0;
                        n_sq_bit = SQ_TOP;
                        n_state  = S_SQB;
                    end
                end
            end
            S_DIV: begin
                n_m = r_m << 1;
                if (w_rem2 >= {1'b0, r_den}) begin
                    n_rem = DNW'(w_rem2 - {1'b0, r_den});
                    n_q   = {r_q[MW-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2[DNW-1:0];
                    n_q   = {r_q[MW-2:0], 1'b0};
                end
                n_cnt = KW'(r_cnt + 1'b1);
                if (r_cnt == KW'(MW - 1)) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                if (|w_qr_rnd[MW:EW-1]) begin
                    n_sim = r_neg ? SIM_MIN : SIM_MAX;
                end else begin
                    n_sim = r_neg ? EW'(-w_qr_rnd[EW-1:0]) : w_qr_rnd[EW-1:0];
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                if ($signed(r_sim) > $signed(r_best)) begin
                    n_best  = r_sim;
                    n_bu    = r_u[UIW-1:0];
                    n_found = 1'b1;
                end
                n_u    = UCW'(r_u + 1'b1);
                n_base = r_base + AW'(MAX_DIM);
                n_i    = '0;
                n_dot  = '0;
                n_nb   = '0;
                if (UCW'(r_u + 1'b1) == r_users) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DOT;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_ov     = 1'b1;
                    n_obu    = w_bu32[SLOT_W-1:0];
                    n_osim   = r_best;
                    n_omatch = r_found &&
                        ($signed({{(33-EW){r_best[EW-1]}}, r_best})
                         >= $signed({{(33-THR_W){i_thr[THR_W-1]}}, i_thr}));
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_users  <= n_users;
        r_i      <= n_i;
        r_u      <= n_u;
        r_base   <= n_base;
        r_na     <= n_na;
        r_dot    <= n_dot;
        r_nb     <= n_nb;
        r_sa     <= n_sa;
        r_sq_x   <= n_sq_x;
        r_sq_r   <= n_sq_r;
        r_sq_bit <= n_sq_bit;
        r_den    <= n_den;
        r_m      <= n_m;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_sim    <= n_sim;
        r_best   <= n_best;
        r_bu     <= n_bu;
        r_found  <= n_found;
        r_obu    <= n_obu;
        r_osim   <= n_osim;
        r_omatch <= n_omatch;
    end

    assign o_stat.idle       = (r_state == S_IDLE);
    assign o_stat.done       = (r_state == S_DONE);
    assign o_out_valid       = r_ov;
    assign o_best_user       = r_obu;
    assign o_best_similarity = r_osim;
    assign o_matched         = r_omatch;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cnm_pkg::*;

    localparam int USERS  = DEF_MAX_USERS;
    localparam int DIM    = DEF_MAX_DIM;
    localparam int LIMIT  = 2_000_000;  // cycles before the run is stopped
    localparam int SETTLE = 24;         // queued store requests drain well inside this
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] user;
        logic [15:0]       sim;
        logic              hit;
    } t_match;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = KIND_STORE;
    logic [SLOT_W-1:0]     i_user_slot = '0;
    logic [INDEX_W-1:0]    i_element_index = '0;
    logic [15:0]           i_element_value = '0;
    logic                  i_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SLOT_W-1:0]     o_best_user;
    logic [15:0]           o_best_similarity;
    logic                  o_matched;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cosine_nearest_match DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block: vector stores, which entries hold data, registers
    logic signed [15:0] ref_mem [USERS*DIM];
    logic signed [15:0] qry_mem [DIM];
    bit                 ref_wr  [USERS*DIM];
    bit                 qry_wr  [DIM];
    int unsigned        vlen_reg = 128;
    int unsigned        ucnt_reg = 0;
    logic signed [15:0] thr_reg  = 16'sd19661;

    t_match match_q[$];   // results still owed by the block, oldest first

    int  errors, n_items, n_searches, n_hits, n_cfg, cycles;
    bit  tx_steady, rx_steady;    // stretches with no idling on either side
    int  hold_len, hold_left, out_gap;

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Q1.15 cosine of query against one slot; round half away, saturate
    function automatic logic [15:0] cos_score(int slot, int len, longint na);
        longint          dot, nb, a, b;
        longint unsigned den, mag, m, r, rem;
        int              i;
        dot = 0;
        nb  = 0;
        for (i = 0; i < len; i++) begin
            a = qry_mem[i];
            b = ref_mem[slot*DIM + i];
            dot += a * b;
            nb  += b * b;
        end
        if (na == 0 || nb == 0) return 16'h0000;
        if (na == 1 && nb == 1) return 16'h0000;   // denominator below 1e-9
        den = int_root(na) * int_root(nb);
        if (den == 0) return 16'h0000;
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        m   = mag * 32768;
        r   = m / den;
        rem = m % den;
        if (rem >= den - rem) r++;
        if (dot < 0) return (r >= 32768) ? 16'h8000 : 16'(64'd0 - r);
        return (r > 32767) ? 16'h7FFF : 16'(r);
    endfunction

    function automatic void predict_item(logic kind, int slot, int idx,
                                         logic [15:0] val, logic last);
        int                 len, users, u, bu;
        longint             na, a;
        logic signed [15:0] best, s;
        bit                 found;
        t_match             res;
        if (kind == KIND_STORE) begin
            ref_mem[slot*DIM + idx] = val;
            ref_wr[slot*DIM + idx]  = 1'b1;
            return;
        end
        qry_mem[idx] = val;
        qry_wr[idx]  = 1'b1;
        if (!last) return;
        len   = (vlen_reg > DIM) ? DIM : vlen_reg;
        users = (ucnt_reg > USERS) ? USERS : ucnt_reg;
        na = 0;
        for (u = 0; u < len; u++) begin
            a = qry_mem[u];
            na += a * a;
        end
        best  = -16'sd32768;   // -1.0 must be strictly beaten
        bu    = 0;
        found = 1'b0;
        if (users == 0) begin
            best = 16'sd0;
        end else begin
            for (u = 0; u < users; u++) begin
                s = cos_score(u, len, na);
                if (s > best) begin
                    best  = s;
                    bu    = u;
                    found = 1'b1;
                end
            end
        end
        res.user = bu[SLOT_W-1:0];
        res.sim  = best;
        res.hit  = found && (best >= thr_reg);
        match_q.insert(match_q.size(), res);
        n_searches++;
    endfunction

    function automatic logic [15:0] rnd_val();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1:       return 16'($urandom_range(0, 400)) - 16'd200;
            2:       return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, an optional long hold, and the result check
    always @(posedge i_clk) begin
        t_match exp_res;
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (o_out_valid && i_out_ready) begin
            if (match_q.size() == 0) begin
                $error("result with nothing expected: user %0d sim %0d",
                       o_best_user, $signed(o_best_similarity));
                errors++;
            end else begin
                exp_res = match_q.pop_front();
                if (o_best_user !== exp_res.user) begin
                    $error("best_user: expected %0d, got %0d", exp_res.user, o_best_user);
                    errors++;
                end
                if (o_best_similarity !== exp_res.sim) begin
                    $error("best_similarity: expected %0d, got %0d",
                           $signed(exp_res.sim), $signed(o_best_similarity));
                    errors++;
                end
                if (o_matched !== exp_res.hit) begin
                    $error("matched: expected %0b, got %0b", exp_res.hit, o_matched);
                    errors++;
                end
                if (exp_res.hit) n_hits++;
            end
            out_gap = rx_steady ? 0 : $urandom_range(0, 7);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // One request; valid is left high so a following request can go back to back
    task automatic send_item(logic kind, int slot, int idx, logic [15:0] val, logic last);
        int gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_user_slot     <= slot[SLOT_W-1:0];
        i_element_index <= idx[INDEX_W-1:0];
        i_element_value <= val;
        i_last          <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(kind, slot, idx, val, last);
        n_items++;
    endtask

    // Drop valid, wait for every owed result, then let queued stores drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VECTOR_LENGTH: vlen_reg = data[VLEN_W-1:0];
            CFG_USER_COUNT:    ucnt_reg = data[UCNT_W-1:0];
            CFG_THRESHOLD:     thr_reg  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // Write every entry a search under the current registers reads, if still empty
    task automatic fill_unwritten();
        int len   = (vlen_reg > DIM) ? DIM : vlen_reg;
        int users = (ucnt_reg > USERS) ? USERS : ucnt_reg;
        for (int u = 0; u < users; u++)
            for (int i = 0; i < len; i++)
                if (!ref_wr[u*DIM + i]) send_item(KIND_STORE, u, i, rnd_val(), 1'b0);
        for (int i = 0; i < len; i++)
            if (!qry_wr[i]) send_item(KIND_QUERY, 0, i, rnd_val(), 1'b0);
    endtask

    task automatic put_vec(logic kind, int slot, logic [15:0] v0, logic [15:0] v1,
                           logic [15:0] v2, logic [15:0] v3);
        send_item(kind, slot, 0, v0, 1'b0);
        send_item(kind, slot, 1, v1, 1'b0);
        send_item(kind, slot, 2, v2, 1'b0);
        send_item(kind, slot, 3, v3, kind == KIND_QUERY);
    endtask

    task automatic test_no_users();
        send_item(KIND_STORE, 5, 7, 16'd123, 1'b1);   // last on a store: no result
        set_reg(CFG_VECTOR_LENGTH, 16'd4);
        fill_unwritten();
        send_item(KIND_QUERY, 0, 3, 16'h8000, 1'b1);  // no users: 0, 0, no match
    endtask

    task automatic test_special_vectors();
        set_reg(CFG_USER_COUNT, 16'd4);
        put_vec(KIND_STORE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero norm
        put_vec(KIND_STORE, 1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        put_vec(KIND_STORE, 2, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        put_vec(KIND_STORE, 3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);  // tie with slot 1
        put_vec(KIND_QUERY, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        set_reg(CFG_THRESHOLD, 16'h7FFF);
        send_item(KIND_QUERY, 0, 3, 16'h8000, 1'b1);
        set_reg(CFG_THRESHOLD, 16'h8000);
        // unit vectors on both sides: denominator too small, similarity 0
        set_reg(CFG_USER_COUNT, 16'd1);
        put_vec(KIND_STORE, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        put_vec(KIND_QUERY, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        // exactly opposite: nothing beats -1.0
        send_item(KIND_STORE, 0, 0, 16'h8000, 1'b0);
        send_item(KIND_QUERY, 0, 0, 16'h7FFF, 1'b1);
    endtask

    task automatic test_register_extremes();
        set_reg(CFG_VECTOR_LENGTH, 16'd0);            // all norms zero
        send_item(KIND_QUERY, 0, 0, 16'h1234, 1'b1);
        set_reg(CFG_UNUSED, 16'hFFFF);                // no register behind this index
        set_reg(CFG_USER_COUNT, 16'd1);
        set_reg(CFG_VECTOR_LENGTH, 16'hFFFF);         // saturates to full length
        fill_unwritten();
        send_item(KIND_QUERY, 0, DIM - 1, rnd_val(), 1'b1);
        set_reg(CFG_VECTOR_LENGTH, 16'd2);
        set_reg(CFG_USER_COUNT, 16'hFFFF);            // saturates to every slot
        fill_unwritten();
        send_item(KIND_QUERY, 0, 1, rnd_val(), 1'b1);
        set_reg(CFG_THRESHOLD, 16'd0);
        send_item(KIND_QUERY, 0, 0, rnd_val(), 1'b1);
    endtask

    task automatic test_random();
        int len, users, op, s, i;
        while (n_items < 1300) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            // mostly short vectors and few users, so that searches stay short
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 12);
            users = $urandom_range(0, 6);
            set_reg(CFG_VECTOR_LENGTH, 16'(len));
            set_reg(CFG_USER_COUNT, 16'(users));
            set_reg(CFG_THRESHOLD, $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(8000, 32767)));
            fill_unwritten();
            repeat (12) begin
                op = $urandom_range(0, 9);
                if (op <= 5) begin
                    // full query; often a noisy copy of an enrolled vector
                    s = (users > 0) ? $urandom_range(0, users - 1) : 0;
                    for (i = 0; i < len; i++)
                        send_item(KIND_QUERY, 0, i,
                                  (op <= 2 && users > 0)
                                      ? ref_mem[s*DIM + i] + 16'($urandom_range(0, 64)) - 16'd32
                                      : rnd_val(),
                                  i == len - 1);
                end else if (op <= 7 && users > 0) begin
                    send_item(KIND_STORE, $urandom_range(0, users - 1),
                              $urandom_range(0, len - 1), rnd_val(),
                              1'($urandom_range(0, 1)));
                end else if (op == 8) begin
                    send_item(KIND_STORE, $urandom_range(0, USERS - 1),
                              $urandom_range(0, DIM - 1), rnd_val(),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_item(KIND_QUERY, 0, $urandom_range(0, DIM - 1), rnd_val(),
                              $urandom_range(0, 3) == 0);
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Results held off for a long stretch while searches keep coming
    task automatic test_backpressure();
        set_reg(CFG_USER_COUNT, 16'd1);               // short searches: results pile up
        hold_len  = 3000;
        tx_steady = 1'b1;
        repeat (8) send_item(KIND_QUERY, 0, 0, rnd_val(), 1'b1);
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_no_users();
        test_special_vectors();
        test_register_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        $display("tb: %0d requests, %0d searches (%0d matches), %0d register writes",
                 n_items, n_searches, n_hits, n_cfg);
        $display("tb: special vectors, saturated registers, long result stall, random mix");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
